[rtl/tlb_lru_pkg.sv]
// Shared types and constants for the TLB with FIFO/LRU replacement.
package tlb_lru_pkg;

    localparam int AGE_W      = 16;
    localparam int SLOT_W     = 4;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 1'd1;

    localparam logic [CFG_DATA_W-1:0] ENTRIES_RESET = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_SCAN,
        ST_FIFO_WR,
        ST_VICTIM_WR,
        ST_POST
    } state_t;

    typedef struct packed {
        logic match;
        logic older;
    } scan_flags_t;

endpackage

[rtl/tlb_fifo_lru_replacement.sv]
// Top level: fully associative TLB, FIFO or LRU replacement, sequenced entry scan.
//
//  port group   dir  fields (low bit up)
//  s_axis       in   kind, page, frame
//  m_axis       out  hit, frame_out, slot, evicted
//  cfg          in   0 policy_lru, 1 entries_in_use
//
// Lookup and LRU insert walk the active entries through the one-read, one-write
// entry RAM, stopping early on a hit or a free entry. FIFO insert writes the
// slot at the FIFO pointer; flush and unused kinds go straight to the post state.
// aresetn is synchronous; it empties every entry and zeroes the FIFO pointer.
// s_tready is high only between operations; a result still waiting holds the next
// operation in its post state.
module tlb_fifo_lru_replacement
    import tlb_lru_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int PAGE_BITS  = 20,
    parameter int FRAME_BITS = 20
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // kind, page, frame
    input  logic [((KIND_W + PAGE_BITS + FRAME_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // hit, frame_out, slot, evicted
    output logic [((FRAME_BITS + SLOT_W + 2 + 7) / 8) * 8 - 1:0] m_tdata,
    input  logic                                        cfg_we,
    input  logic [CFG_IDX_W-1:0]                        cfg_idx,
    input  logic [CFG_DATA_W-1:0]                       cfg_wdata
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
    localparam int OUT_TW = ((FRAME_BITS + SLOT_W + 2 + 7) / 8) * 8;
    localparam int PG_LO  = KIND_W;
    localparam int FR_LO  = KIND_W + PAGE_BITS;

    state_t state_reg, state_next;

    logic                  policy_reg;
    logic [CFG_DATA_W-1:0] eiu_reg;

    logic [KIND_W-1:0]     kind_reg, kind_next;
    logic [PAGE_BITS-1:0]  page_reg, page_next;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      victim_reg, victim_next;
    logic [AGE_W-1:0]      oldest_reg, oldest_next;
    logic [IDX_W-1:0]      fifo_ptr_reg, fifo_ptr_next;
    logic [ENTRIES-1:0]    valid_reg, valid_next;

    logic                  hit_reg, hit_next;
    logic [FRAME_BITS-1:0] fout_reg, fout_next;
    logic [IDX_W-1:0]      slot_reg, slot_next;
    logic                  evict_reg, evict_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_TW-1:0]     m_tdata_reg, m_tdata_next;

    logic [CMP_W-1:0]      eiu_ext;
    logic [CMP_W-1:0]      n_cmp;
    logic [CNT_W-1:0]      n_act;
    logic [IDX_W-1:0]      last_idx;
    logic [IDX_W-1:0]      fifo_slot;
    logic                  s_accept;
    logic [KIND_W-1:0]     s_kind;

    logic                  mem_clear;
    logic [IDX_W-1:0]      rd_addr;
    logic [PAGE_BITS-1:0]  rd_page;
    logic [FRAME_BITS-1:0] rd_frame;
    logic [AGE_W-1:0]      rd_age;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [PAGE_BITS-1:0]  wr_page;
    logic [FRAME_BITS-1:0] wr_frame;
    logic [AGE_W-1:0]      wr_age;

    logic [AGE_W-1:0]      aged;
    scan_flags_t           flags;

    tlb_lru_entry_ram #(
        .ENTRIES    (ENTRIES),
        .PAGE_BITS  (PAGE_BITS),
        .FRAME_BITS (FRAME_BITS)
    ) u_ram (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (mem_clear),
        .rd_addr  (rd_addr),
        .rd_page  (rd_page),
        .rd_frame (rd_frame),
        .rd_age   (rd_age),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_page  (wr_page),
        .wr_frame (wr_frame),
        .wr_age   (wr_age)
    );

    tlb_lru_age_unit #(
        .PAGE_BITS (PAGE_BITS)
    ) u_age (
        .row_valid (valid_reg[idx_reg]),
        .row_page  (rd_page),
        .row_age   (rd_age),
        .key_page  (page_reg),
        .oldest    (oldest_reg),
        .aged      (aged),
        .flags     (flags)
    );

    // active entry count, clamped to 1..ENTRIES
    always_comb begin
        eiu_ext = CMP_W'(eiu_reg);
        if (eiu_reg == '0) begin
            n_cmp = CMP_W'(1);
        end else if (eiu_ext > CMP_W'(ENTRIES)) begin
            n_cmp = CMP_W'(ENTRIES);
        end else begin
            n_cmp = eiu_ext;
        end
        n_act     = CNT_W'(n_cmp);
        last_idx  = IDX_W'(n_act - 1'b1);
        fifo_slot = (CNT_W'(fifo_ptr_reg) >= n_act) ? '0 : fifo_ptr_reg;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign s_kind   = s_tdata[KIND_W-1:0];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= 1'b0;
            eiu_reg    <= ENTRIES_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_POLICY:  policy_reg <= cfg_wdata[0];
                CFG_ENTRIES: eiu_reg    <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fifo_ptr_reg <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fifo_ptr_reg <= fifo_ptr_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        page_reg    <= page_next;
        frame_reg   <= frame_next;
        idx_reg     <= idx_next;
        victim_reg  <= victim_next;
        oldest_reg  <= oldest_next;
        hit_reg     <= hit_next;
        fout_reg    <= fout_next;
        slot_reg    <= slot_next;
        evict_reg   <= evict_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        page_next     = page_reg;
        frame_next    = frame_reg;
        idx_next      = idx_reg;
        victim_next   = victim_reg;
        oldest_next   = oldest_reg;
        fifo_ptr_next = fifo_ptr_reg;
        valid_next    = valid_reg;
        hit_next      = hit_reg;
        fout_next     = fout_reg;
        slot_next     = slot_reg;
        evict_next    = evict_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        mem_clear     = 1'b0;
        rd_addr       = idx_reg;
        wr_en         = 1'b0;
        wr_addr       = idx_reg;
        wr_page       = rd_page;
        wr_frame      = rd_frame;
        wr_age        = aged;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    kind_next   = s_kind;
                    page_next   = s_tdata[PG_LO +: PAGE_BITS];
                    frame_next  = s_tdata[FR_LO +: FRAME_BITS];
                    victim_next = '0;
                    oldest_next = '0;
                    hit_next    = 1'b0;
                    fout_next   = '0;
                    slot_next   = '0;
                    evict_next  = 1'b0;
                    idx_next    = '0;
                    priority if (s_kind == KIND_LOOKUP) begin
                        state_next = ST_PRIME;
                    end else if (s_kind == KIND_INSERT) begin
                        if (!policy_reg) begin
                            idx_next = fifo_slot;
                        end
                        state_next = ST_PRIME;
                    end else if (s_kind == KIND_FLUSH) begin
                        mem_clear  = 1'b1;
                        valid_next = '0;
                        state_next = ST_POST;
                    end else begin
                        state_next = ST_POST;
                    end
                end
            end
            ST_PRIME: begin
                state_next = (kind_reg == KIND_INSERT && !policy_reg) ? ST_FIFO_WR : ST_SCAN;
            end
            ST_SCAN: begin
                // read of the next row overlaps work on this one
                rd_addr = idx_reg + 1'b1;
                wr_en   = 1'b1;
                if (kind_reg == KIND_LOOKUP) begin
                    if (flags.match) begin
                        wr_age     = '0;
                        hit_next   = 1'b1;
                        fout_next  = rd_frame;
                        slot_next  = idx_reg;
                        state_next = ST_POST;
                    end else if (idx_reg == last_idx) begin
                        state_next = ST_POST;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end else begin
                    if (!valid_reg[idx_reg]) begin
                        wr_page             = page_reg;
                        wr_frame            = frame_reg;
                        wr_age              = '0;
                        valid_next[idx_reg] = 1'b1;
                        slot_next           = idx_reg;
                        state_next          = ST_POST;
                    end else begin
                        if (flags.older) begin
                            oldest_next = aged;
                            victim_next = idx_reg;
                        end
                        if (idx_reg == last_idx) begin
                            state_next = ST_VICTIM_WR;
                        end else begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                end
            end
            ST_VICTIM_WR: begin
                wr_en                  = 1'b1;
                wr_addr                = victim_reg;
                wr_page                = page_reg;
                wr_frame               = frame_reg;
                wr_age                 = '0;
                valid_next[victim_reg] = 1'b1;
                slot_next              = victim_reg;
                evict_next             = 1'b1;
                state_next             = ST_POST;
            end
            ST_FIFO_WR: begin
                wr_en               = 1'b1;
                wr_page             = page_reg;
                wr_frame            = frame_reg;
                wr_age              = rd_age;
                valid_next[idx_reg] = 1'b1;
                slot_next           = idx_reg;
                evict_next          = valid_reg[idx_reg];
                fifo_ptr_next       = (CNT_W'(idx_reg) + 1'b1 < n_act) ? idx_reg + 1'b1 : '0;
                state_next          = ST_POST;
            end
            ST_POST: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_TW'({evict_reg, SLOT_W'(slot_reg), fout_reg, hit_reg});
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_post_only: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_POST))
        else $error("result beat raised outside the post state");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (CNT_W'(idx_reg) < n_act))
        else $error("scan index beyond active entries");

    a_flush_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_kind == KIND_FLUSH) |=> (valid_reg == '0))
        else $error("flush left a valid entry");

    a_fifo_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIFO_WR) |=> (CNT_W'(fifo_ptr_reg) < n_act))
        else $error("fifo pointer beyond active entries");

endmodule

[rtl/tlb_lru_entry_ram.sv]
// Entry store: page, frame and age rows with registered read and per-row live bits.
module tlb_lru_entry_ram
    import tlb_lru_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int PAGE_BITS  = 20,
    parameter int FRAME_BITS = 20
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        clear,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
    output logic [PAGE_BITS-1:0]                        rd_page,
    output logic [FRAME_BITS-1:0]                       rd_frame,
    output logic [AGE_W-1:0]                            rd_age,
    input  logic                                        wr_en,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
    input  logic [PAGE_BITS-1:0]                        wr_page,
    input  logic [FRAME_BITS-1:0]                       wr_frame,
    input  logic [AGE_W-1:0]                            wr_age
);

    logic [PAGE_BITS-1:0]  page_mem  [ENTRIES];
    logic [FRAME_BITS-1:0] frame_mem [ENTRIES];
    logic [AGE_W-1:0]      age_mem   [ENTRIES];
    logic [ENTRIES-1:0]    live_reg;

    logic [PAGE_BITS-1:0]  rd_page_reg;
    logic [FRAME_BITS-1:0] rd_frame_reg;
    logic [AGE_W-1:0]      rd_age_reg;
    logic                  rd_live_reg;

    // a row not written since reset or flush reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg <= '0;
        end else if (clear) begin
            live_reg <= '0;
        end else if (wr_en) begin
            live_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            page_mem[wr_addr]  <= wr_page;
            frame_mem[wr_addr] <= wr_frame;
            age_mem[wr_addr]   <= wr_age;
        end
        rd_page_reg  <= page_mem[rd_addr];
        rd_frame_reg <= frame_mem[rd_addr];
        rd_age_reg   <= age_mem[rd_addr];
        rd_live_reg  <= live_reg[rd_addr];
    end

    assign rd_page  = rd_live_reg ? rd_page_reg  : '0;
    assign rd_frame = rd_live_reg ? rd_frame_reg : '0;
    assign rd_age   = rd_live_reg ? rd_age_reg   : '0;

endmodule

[rtl/tlb_lru_age_unit.sv]
// Shared scan unit: page match, saturating age step and oldest-age compare.
module tlb_lru_age_unit
    import tlb_lru_pkg::*;
#(
    parameter int PAGE_BITS = 20
) (
    input  logic                 row_valid,
    input  logic [PAGE_BITS-1:0] row_page,
    input  logic [AGE_W-1:0]     row_age,
    input  logic [PAGE_BITS-1:0] key_page,
    input  logic [AGE_W-1:0]     oldest,
    output logic [AGE_W-1:0]     aged,
    output scan_flags_t          flags
);

    always_comb begin
        aged        = (row_age == AGE_MAX) ? row_age : row_age + 1'b1;
        flags.match = row_valid && (row_page == key_page);
        flags.older = aged > oldest;
    end

endmodule
